### design/error_code_intern_table_assert.svh
// Assertion macros for the error code intern table.
`ifndef ERROR_CODE_INTERN_TABLE_ASSERT_SVH
`define ERROR_CODE_INTERN_TABLE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define ECIT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ecit: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define ECIT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ecit: next-cycle check failed");

`endif

### design/ecit_pkg.sv
// Types, codes and defaults shared by the error code intern table.
package ecit_pkg;

  localparam int TABLE_SLOTS_DEF = 256;

  localparam int CODE_W = 32;
  localparam int REG_W  = 31;

  // commands
  localparam logic [1:0] CMD_ADD     = 2'd0;
  localparam logic [1:0] CMD_FROMABI = 2'd1;
  localparam logic [1:0] CMD_TOABI   = 2'd2;

  // result status
  localparam logic [1:0] ST_FOUND   = 2'd0;
  localparam logic [1:0] ST_NEW     = 2'd1;
  localparam logic [1:0] ST_REFUSED = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_ABI_BASE   = 2'd0;
  localparam logic [1:0] CFG_IMPL_OTHER = 2'd1;
  localparam logic [1:0] CFG_ABI_OTHER  = 2'd2;

  localparam logic [REG_W-1:0] ABI_BASE_RST   = 31'd16384;
  localparam logic [REG_W-1:0] IMPL_OTHER_RST = 31'd15;
  localparam logic [REG_W-1:0] ABI_OTHER_RST  = 31'd15;

  typedef struct packed {
    logic [1:0]               command;
    logic signed [CODE_W-1:0] code_in;
  } in_word_t;

  typedef struct packed {
    logic signed [CODE_W-1:0] code_out;
    logic [1:0]               status;
  } out_word_t;

endpackage

### design/error_code_intern_table.sv
// Top level: append-only intern table mapping foreign error codes to dense numbers.
//
//  channel | dir | handshake            | word
//  --------+-----+----------------------+---------------------------------
//  in      | in  | in_valid / in_stall  | ecit_pkg::in_word_t  (command, code_in)
//  out     | out | out_valid / out_stall| ecit_pkg::out_word_t (code_out, status)
//  cfg     | in  | cfg_we               | cfg_index, cfg_wdata (31 bit)
//
// Add, unused, invalid from-abi: decode, done, then output register; valid from-abi adds fetch.
// To-abi: decode, then scan compares up to the entry count, newest first, then done:
// the single RAM read port delivers one entry per cycle to the one comparator.
// The next word is taken once the sequencer is back in idle, even while a result waits.
// A finished result waits in its own state until the output register is free.
// Reset (rst_n, synchronous) clears state, entry count, out_valid, cfg; not RAM or data regs.
module error_code_intern_table #(
  parameter int TABLE_SLOTS = ecit_pkg::TABLE_SLOTS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  ecit_pkg::in_word_t         in_data,
  output logic                       out_valid,
  input  logic                       out_stall,
  output ecit_pkg::out_word_t        out_data,
  input  logic                       cfg_we,
  input  logic [1:0]                 cfg_index,
  input  logic [ecit_pkg::REG_W-1:0] cfg_wdata
);

  `include "error_code_intern_table_assert.svh"

  localparam int IW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int CW = $clog2(TABLE_SLOTS + 1);
  localparam int CODE_W = ecit_pkg::CODE_W;
  localparam logic [CW-1:0] SLOTS_C = CW'(TABLE_SLOTS);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_FETCH  = 3'd3;
  localparam logic [2:0] S_DONE   = 3'd4;

  logic [2:0]                 state_r, state_nxt;
  ecit_pkg::in_word_t         item_r;
  logic [CW-1:0]              cnt_r, cnt_nxt;
  logic [IW-1:0]              idx_r, idx_nxt;
  ecit_pkg::out_word_t        res_r, res_nxt;
  ecit_pkg::out_word_t        out_r;
  logic                       out_vld_r;
  logic [ecit_pkg::REG_W-1:0] base_r, impl_r, abio_r;

  logic              in_acc, out_free, full, code_nz;
  logic [CW-1:0]     cnt_m1;
  logic [IW-1:0]     idx_m1;
  logic [32:0]       rel;
  logic              rel_ok;
  logic              ram_we;
  logic [IW-1:0]     ram_raddr;
  logic [CODE_W-1:0] ram_rdata;
  logic [CODE_W-1:0] code_u;
  logic [CODE_W-1:0] dense_cnt, dense_idx;

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_vld_r || !out_stall;
  assign out_valid = out_vld_r;
  assign out_data  = out_r;

  assign code_u    = $unsigned(item_r.code_in);
  assign code_nz   = (code_u != '0);
  assign full      = (cnt_r == SLOTS_C);
  assign cnt_m1    = cnt_r - 1'b1;
  assign idx_m1    = idx_r - 1'b1;
  assign dense_cnt = {1'b0, base_r} + CODE_W'(cnt_r);
  assign dense_idx = {1'b0, base_r} + CODE_W'(idx_r);

  // dense number minus base, as a 33-bit two's complement value
  assign rel    = {item_r.code_in[CODE_W-1], code_u} - {2'b00, base_r};
  assign rel_ok = !rel[32] && (rel[31:0] < 32'(cnt_r));

  ecit_ram #(
    .WIDTH(CODE_W),
    .DEPTH(TABLE_SLOTS),
    .AW   (IW)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(cnt_r[IW-1:0]),
    .wdata(code_u),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    idx_nxt   = idx_r;
    res_nxt   = res_r;
    ram_we    = 1'b0;
    ram_raddr = idx_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        state_nxt = S_DONE;
        res_nxt   = '{code_out: '0, status: ecit_pkg::ST_REFUSED};
        case (item_r.command)
          ecit_pkg::CMD_ADD: begin
            if (code_nz && !full) begin
              ram_we  = 1'b1;
              cnt_nxt = cnt_r + 1'b1;
              res_nxt = '{code_out: dense_cnt, status: ecit_pkg::ST_NEW};
            end
          end
          ecit_pkg::CMD_FROMABI: begin
            ram_raddr = rel[IW-1:0];
            if (rel_ok) begin
              state_nxt = S_FETCH;
            end else begin
              res_nxt = '{code_out: {1'b0, impl_r}, status: ecit_pkg::ST_REFUSED};
            end
          end
          ecit_pkg::CMD_TOABI: begin
            if (cnt_r != '0) begin
              // start the scan at the newest entry
              ram_raddr = cnt_m1[IW-1:0];
              idx_nxt   = cnt_m1[IW-1:0];
              state_nxt = S_SCAN;
            end else if (code_nz) begin
              ram_we  = 1'b1;
              cnt_nxt = cnt_r + 1'b1;
              res_nxt = '{code_out: dense_cnt, status: ecit_pkg::ST_NEW};
            end else begin
              res_nxt = '{code_out: {1'b0, abio_r}, status: ecit_pkg::ST_REFUSED};
            end
          end
          default: begin
            res_nxt = '{code_out: '0, status: ecit_pkg::ST_REFUSED};
          end
        endcase
      end
      S_SCAN: begin
        // ram_rdata holds entry idx_r
        if (ram_rdata == code_u) begin
          res_nxt   = '{code_out: dense_idx, status: ecit_pkg::ST_FOUND};
          state_nxt = S_DONE;
        end else if (idx_r == '0) begin
          state_nxt = S_DONE;
          if (code_nz && !full) begin
            ram_we  = 1'b1;
            cnt_nxt = cnt_r + 1'b1;
            res_nxt = '{code_out: dense_cnt, status: ecit_pkg::ST_NEW};
          end else begin
            res_nxt = '{code_out: {1'b0, abio_r}, status: ecit_pkg::ST_REFUSED};
          end
        end else begin
          ram_raddr = idx_m1;
          idx_nxt   = idx_m1;
        end
      end
      S_FETCH: begin
        res_nxt   = '{code_out: ram_rdata, status: ecit_pkg::ST_FOUND};
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      cnt_r     <= '0;
      out_vld_r <= 1'b0;
      base_r    <= ecit_pkg::ABI_BASE_RST;
      impl_r    <= ecit_pkg::IMPL_OTHER_RST;
      abio_r    <= ecit_pkg::ABI_OTHER_RST;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (state_r == S_DONE && out_free) begin
        out_vld_r <= 1'b1;
      end else if (!out_stall) begin
        out_vld_r <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_index)
          ecit_pkg::CFG_ABI_BASE:   base_r <= cfg_wdata;
          ecit_pkg::CFG_IMPL_OTHER: impl_r <= cfg_wdata;
          ecit_pkg::CFG_ABI_OTHER:  abio_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      item_r <= in_data;
    end
    idx_r <= idx_nxt;
    res_r <= res_nxt;
    if (state_r == S_DONE && out_free) begin
      out_r <= res_r;
    end
  end

  `ECIT_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_r <= SLOTS_C)
  `ECIT_ASSERT_NEXT(a_cnt_step, ram_we, cnt_r == CW'($past(cnt_r) + 1'b1))
  `ECIT_ASSERT_NOW(a_scan_idx, state_r == S_SCAN, CW'(idx_r) < cnt_r)
  `ECIT_ASSERT_NEXT(a_accept_decode, in_acc, state_r == S_DECODE)
  `ECIT_ASSERT_NOW(a_write_room, ram_we, !full && code_nz)

endmodule

### design/ecit_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ecit_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
